// ===== src/prma_pkg.sv =====
`timescale 1ns / 1ps

package prma_pkg;

    // Default sizes of the price history.
    localparam int RING_DEPTH_DEF = 8192;
    localparam int PRICE_BITS_DEF = 32;

    // Result layout: nine lag ratios, then three window averages.
    localparam int NUM_RATIOS  = 9;
    localparam int NUM_AVGS    = 3;
    localparam int NUM_RESULTS = 12;

    localparam int SAMPLE_BITS = 32;
    localparam int LEN_BITS    = 16;
    localparam int SEEN_BITS   = 14;
    localparam int SUM_BITS    = 48;
    localparam int VALUE_BITS  = 33;
    localparam int FRAC_SHIFT  = 16;

    localparam logic [SEEN_BITS-1:0]  SEEN_MAX      = 14'h3FFF;
    localparam logic [VALUE_BITS-1:0] VALUE_POS_MAX = 33'h0_FFFF_FFFF;
    localparam logic [VALUE_BITS-1:0] VALUE_NEG_MAG = 33'h1_0000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAGS_FIRST = 2'd0;
    localparam logic [1:0] CFG_LAGS_NEXT  = 2'd1;
    localparam logic [1:0] CFG_LAG_LONG   = 2'd2;
    localparam logic [1:0] CFG_WINDOWS    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [63:0] LAGS_FIRST_RST = 64'h00B4_0078_003C_001E;
    localparam logic [63:0] LAGS_NEXT_RST  = 64'h0708_04B0_0258_012C;
    localparam logic [15:0] LAG_LONG_RST   = 16'd3600;
    localparam logic [47:0] WINDOWS_RST    = 48'h1770_05DC_012C;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_DIV,
        ST_SAT,
        ST_OUT
    } state_t;

endpackage

// ===== src/prma_ram.sv =====
`timescale 1ns / 1ps

module prma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/price_ring_ratio_and_moving_average.sv =====
`timescale 1ns / 1ps
// Order: an accepted sample goes to ST_ADDR (ring read issued), then ST_READ; a result that
// needs a divide then stays in ST_DIV, where the single shared divider makes one quotient
// bit per cycle up to DW bits, DW = max(PRICE_BITS + 16, 48), then passes ST_SAT to ST_OUT;
// an invalid result goes from ST_READ to ST_OUT. Each further result starts at ST_ADDR, and
// ST_OUT holds on an output stall. A new sample is taken only in ST_IDLE, after all twelve.
// Reset: control, position, sample count and running sums clear; the history is not cleared.

module price_ring_ratio_and_moving_average #(
    parameter int RING_DEPTH = prma_pkg::RING_DEPTH_DEF,
    parameter int PRICE_BITS = prma_pkg::PRICE_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [prma_pkg::SAMPLE_BITS-1:0]        price_sample,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [3:0]                              indicator,
    output logic signed [prma_pkg::VALUE_BITS-1:0]  value,
    output logic                                    valid_res,
    output logic                                    last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [1:0]                              cfg_index,
    input  logic [63:0]                             cfg_data
);

    import prma_pkg::*;

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int PB    = PRICE_BITS;
    localparam int DW    = (PRICE_BITS + 16 > 48) ? PRICE_BITS + 16 : 48;
    localparam int CW    = $clog2(DW + 1);
    localparam int LW    = LEN_BITS + 1;

    state_t                state_reg, state_next;
    logic [3:0]            k_reg, k_next;
    logic [PB-1:0]         now_reg, now_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [SEEN_BITS-1:0]  seen_reg, seen_next;
    logic [SUM_BITS-1:0]   sum_reg [NUM_AVGS];
    logic [SUM_BITS-1:0]   sum_next;
    logic                  sum_we;
    logic [PB-1:0]         rem_reg, rem_next;
    logic [DW-1:0]         quo_reg, quo_next;
    logic [PB-1:0]         div_reg, div_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  have_reg, have_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  ok_reg, ok_next;

    logic [63:0]           lags_first_reg;
    logic [63:0]           lags_next_reg;
    logic [15:0]           lag_long_reg;
    logic [47:0]           windows_reg;

    logic [LEN_BITS-1:0]   cur_len;
    logic                  have_c;
    logic [LW-1:0]         pos_w;
    logic [LW-1:0]         len_w;
    logic [LW-1:0]         idx_w;
    logic [AW-1:0]         rd_addr;
    logic [PB-1:0]         rd_data;
    logic                  rd_en;
    logic                  in_acc;
    logic [PB-1:0]         now_c;
    logic [1:0]            sidx;
    logic                  is_avg;
    logic [PB-1:0]         diff;
    logic [PB:0]           trial;
    logic                  ge;
    logic [VALUE_BITS-1:0] qsat;

    assign in_acc = in_valid && in_ready;
    assign now_c  = PB'(price_sample);
    assign cfg_ready = 1'b1;

    // Lag or window length of the result in hand.
    always_comb
    begin
        case (k_reg)
            4'd0:    cur_len = lags_first_reg[15:0];
            4'd1:    cur_len = lags_first_reg[31:16];
            4'd2:    cur_len = lags_first_reg[47:32];
            4'd3:    cur_len = lags_first_reg[63:48];
            4'd4:    cur_len = lags_next_reg[15:0];
            4'd5:    cur_len = lags_next_reg[31:16];
            4'd6:    cur_len = lags_next_reg[47:32];
            4'd7:    cur_len = lags_next_reg[63:48];
            4'd8:    cur_len = lag_long_reg;
            4'd9:    cur_len = windows_reg[15:0];
            4'd10:   cur_len = windows_reg[31:16];
            4'd11:   cur_len = windows_reg[47:32];
            default: cur_len = '0;
        endcase
    end

    // History depth check and ring address of the old sample.
    assign len_w  = LW'(cur_len);
    assign pos_w  = LW'(pos_reg);
    assign have_c = (len_w < LW'(RING_DEPTH)) &&
                    (LW'(seen_reg) > len_w);
    assign idx_w  = (pos_w >= len_w) ? (pos_w - len_w)
                                     : (pos_w + LW'(RING_DEPTH) - len_w);
    assign rd_addr = idx_w[AW-1:0];

    assign is_avg = (k_reg >= 4'(NUM_RATIOS));
    assign sidx   = 2'(k_reg - 4'(NUM_RATIOS));
    assign diff   = (now_reg >= rd_data) ? (now_reg - rd_data) : (rd_data - now_reg);

    // Running sum: add the new sample and drop the one a window back.
    assign sum_next = sum_reg[sidx] + SUM_BITS'(now_reg)
                      - (have_reg ? SUM_BITS'(rd_data) : SUM_BITS'(0));

    // One restoring divide step.
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign ge    = (trial >= {1'b0, div_reg});

    // Saturated magnitude of the quotient.
    always_comb
    begin
        if (neg_reg)
        begin
            qsat = (quo_reg > DW'(VALUE_NEG_MAG)) ? VALUE_NEG_MAG : VALUE_BITS'(quo_reg);
        end
        else
        begin
            qsat = (quo_reg > DW'(VALUE_POS_MAX)) ? VALUE_POS_MAX : VALUE_BITS'(quo_reg);
        end
    end

    prma_ram #(
        .WIDTH (PB),
        .DEPTH (RING_DEPTH)
    ) u_hist (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (pos_reg),
        .wr_data (now_c),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR: state_next = ST_READ;
            ST_READ:
            begin
                if (!have_reg || (!is_avg && rd_data == '0) || (is_avg && cur_len == '0))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CW'(DW - 1))
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = (k_reg == 4'(NUM_RESULTS - 1)) ? ST_IDLE : ST_ADDR;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory controls.
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        rd_en     = (state_reg == ST_ADDR);
        sum_we    = (state_reg == ST_READ) && is_avg;
    end

    // Datapath next values.
    always_comb
    begin
        k_next     = k_reg;
        now_next   = now_reg;
        pos_next   = pos_reg;
        seen_next  = seen_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        have_next  = have_reg;
        value_next = value_reg;
        ok_next    = ok_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next  = now_c;
                    k_next    = '0;
                    seen_next = (seen_reg < SEEN_MAX) ? seen_reg + 1'b1 : seen_reg;
                end
            end
            ST_ADDR:
            begin
                have_next = have_c;
            end
            ST_READ:
            begin
                rem_next   = '0;
                cnt_next   = '0;
                value_next = '0;
                ok_next    = 1'b0;
                if (is_avg)
                begin
                    neg_next = 1'b0;
                    quo_next = DW'(sum_next);
                    div_next = PB'(cur_len);
                end
                else
                begin
                    neg_next = (now_reg < rd_data);
                    quo_next = DW'({diff, 16'b0});
                    div_next = rd_data;
                end
            end
            ST_DIV:
            begin
                rem_next = ge ? PB'(trial - {1'b0, div_reg}) : PB'(trial);
                quo_next = {quo_reg[DW-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
            end
            ST_SAT:
            begin
                value_next = neg_reg ? (VALUE_BITS'(0) - qsat) : qsat;
                ok_next    = 1'b1;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    k_next = k_reg + 1'b1;
                    if (k_reg == 4'(NUM_RESULTS - 1))
                    begin
                        pos_next = (32'(pos_reg) + 1 >= RING_DEPTH) ? '0 : pos_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            pos_reg   <= '0;
            seen_reg  <= '0;
            cnt_reg   <= '0;
            have_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            for (int i = 0; i < NUM_AVGS; i++)
            begin
                sum_reg[i] <= '0;
            end
            lags_first_reg <= LAGS_FIRST_RST;
            lags_next_reg  <= LAGS_NEXT_RST;
            lag_long_reg   <= LAG_LONG_RST;
            windows_reg    <= WINDOWS_RST;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            pos_reg   <= pos_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            have_reg  <= have_next;
            ok_reg    <= ok_next;
            if (sum_we)
            begin
                sum_reg[sidx] <= sum_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_LAGS_FIRST: lags_first_reg <= cfg_data;
                    CFG_LAGS_NEXT:  lags_next_reg  <= cfg_data;
                    CFG_LAG_LONG:   lag_long_reg   <= cfg_data[15:0];
                    CFG_WINDOWS:    windows_reg    <= cfg_data[47:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        div_reg   <= div_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
    end

    assign indicator = k_reg;
    assign value     = value_reg;
    assign valid_res = ok_reg;
    assign last      = (k_reg == 4'(NUM_RESULTS - 1));

endmodule

// ===== test/prma_checker.sv =====
`timescale 1ns / 1ps

module prma_checker
    import prma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] price_sample,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [3:0]             indicator,
    input  logic [VALUE_BITS-1:0]  value,
    input  logic                   valid_res,
    input  logic                   last,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [63:0]            cfg_data,
    output int                     errors,
    output int                     pending,
    output int                     checked
);

    localparam int DEPTH = RING_DEPTH_DEF;

    typedef struct packed {
        logic [3:0]            ind;
        logic [VALUE_BITS-1:0] val;
        logic                  ok;
        logic                  lst;
    } indicator_word_t;

    // Shadow copy of the registers and of the block's state.
    logic [63:0]          lags_first;
    logic [63:0]          lags_next;
    logic [15:0]          lag_long;
    logic [47:0]          windows;
    logic [31:0]          price_ring [0:DEPTH-1];
    logic [12:0]          ring_pos;
    logic [SEEN_BITS-1:0] seen_count;
    logic [SUM_BITS-1:0]  running_sum [0:NUM_AVGS-1];

    indicator_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic logic [15:0] lag_for(int i);
        if (i < 4)
            return lags_first[16*i +: 16];
        else if (i < 8)
            return lags_next[16*(i-4) +: 16];
        return lag_long;
    endfunction

    // Fractional change in Q16.16, truncated toward zero and saturated.
    function automatic logic [VALUE_BITS-1:0] rate_of_change(logic [31:0] now, logic [31:0] old);
        logic [63:0] mag;
        logic [63:0] q;
        if (now >= old)
        begin
            mag = 64'(now - old) << FRAC_SHIFT;
            q = mag / old;
            if (q > 64'(VALUE_POS_MAX))
                q = 64'(VALUE_POS_MAX);
            return q[VALUE_BITS-1:0];
        end
        mag = 64'(old - now) << FRAC_SHIFT;
        q = mag / old;
        if (q > 64'(VALUE_NEG_MAG))
            q = 64'(VALUE_NEG_MAG);
        return {VALUE_BITS{1'b0}} - q[VALUE_BITS-1:0];
    endfunction

    // Store the sample and queue the twelve words that it causes.
    task automatic predict_indicators(logic [31:0] now);
        indicator_word_t w;
        logic [15:0]     len;
        logic [31:0]     old;
        logic [47:0]     s;
        logic [63:0]     q;
        logic            have;
        price_ring[ring_pos] = now;
        if (seen_count < SEEN_MAX)
            seen_count = seen_count + 1'b1;
        for (int i = 0; i < NUM_RATIOS; i++)
        begin
            len = lag_for(i);
            w = '0;
            w.ind = 4'(i);
            if (len < DEPTH && 16'(seen_count) > len)
            begin
                old = price_ring[13'(ring_pos - len[12:0])];
                if (old != 0)
                begin
                    w.val = rate_of_change(now, old);
                    w.ok = 1'b1;
                end
            end
            expected_words.push_back(w);
        end
        for (int i = 0; i < NUM_AVGS; i++)
        begin
            len = windows[16*i +: 16];
            w = '0;
            w.ind = 4'(NUM_RATIOS + i);
            w.lst = (i == NUM_AVGS - 1);
            s = running_sum[i] + now;
            have = (len < DEPTH && 16'(seen_count) > len);
            if (have)
                s = s - price_ring[13'(ring_pos - len[12:0])];
            running_sum[i] = s;
            if (have && len != 0)
            begin
                q = 64'(s) / len;
                if (q > 64'(VALUE_POS_MAX))
                    q = 64'(VALUE_POS_MAX);
                w.val = q[VALUE_BITS-1:0];
                w.ok = 1'b1;
            end
            expected_words.push_back(w);
        end
        ring_pos = ring_pos + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        indicator_word_t want;
        if (!rst_n)
        begin
            lags_first = LAGS_FIRST_RST;
            lags_next = LAGS_NEXT_RST;
            lag_long = LAG_LONG_RST;
            windows = WINDOWS_RST;
            ring_pos = '0;
            seen_count = '0;
            for (int i = 0; i < NUM_AVGS; i++)
                running_sum[i] = '0;
            expected_words.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            // Register writes.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LAGS_FIRST: lags_first = cfg_data;
                    CFG_LAGS_NEXT:  lags_next = cfg_data;
                    CFG_LAG_LONG:   lag_long = cfg_data[15:0];
                    CFG_WINDOWS:    windows = cfg_data[47:0];
                    default:        ;
                endcase
            end
            // Result words against the oldest expectation.
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: ind %0d value %h ok %b last %b",
                                 indicator, value, valid_res, last);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (indicator !== want.ind || value !== want.val ||
                        valid_res !== want.ok || last !== want.lst)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: exp ind %0d value %h ok %b last %b, ",
                                      "got ind %0d value %h ok %b last %b"},
                                     want.ind, want.val, want.ok, want.lst,
                                     indicator, value, valid_res, last);
                    end
                end
            end
            // Accepted samples.
            if (in_valid && in_ready)
                predict_indicators(price_sample);
        end
    end

endmodule

// ===== test/price_ring_ratio_and_moving_average_tb.sv =====
`timescale 1ns / 1ps

module price_ring_ratio_and_moving_average_tb;
    import prma_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [SAMPLE_BITS-1:0] price_sample;
    logic                   out_valid;
    logic                   out_ready;
    logic [3:0]             indicator;
    logic [VALUE_BITS-1:0]  value;
    logic                   valid_res;
    logic                   last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [1:0]             cfg_index;
    logic [63:0]            cfg_data;

    int errors;
    int pending;
    int checked;
    int cycles;
    int samples_sent;
    int cfg_writes;
    int burst_left;
    int stall_mode;
    logic [31:0] prev_price;

    price_ring_ratio_and_moving_average i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .price_sample(price_sample),
        .out_valid(out_valid), .out_ready(out_ready), .indicator(indicator),
        .value(value), .valid_res(valid_res), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    prma_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .price_sample(price_sample),
        .out_valid(out_valid), .out_ready(out_ready), .indicator(indicator),
        .value(value), .valid_res(valid_res), .last(last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Safety net against a hung handshake.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver switches among four stall habits, picked at random.
    always @(negedge clk)
    begin
        if (cycles % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ((cycles / 5) % 3 != 0);
        endcase
    end

    // Called at a falling edge; leaves the word held until it is taken.
    task automatic send_word(logic [31:0] p);
        in_valid = 1'b1;
        price_sample = p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        samples_sent++;
        prev_price = p;
        burst_left--;
        if (burst_left <= 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(0, 12))
                @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // Drains every outstanding word, then lets the block settle.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (80)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    task automatic set_all(logic [63:0] first, logic [63:0] next, logic [15:0] longest,
                           logic [47:0] wins);
        wait_idle();
        write_reg(CFG_LAGS_FIRST, first);
        write_reg(CFG_LAGS_NEXT, next);
        write_reg(CFG_LAG_LONG, {48'd0, longest});
        write_reg(CFG_WINDOWS, {16'd0, wins});
    endtask

    function automatic logic [15:0] pick_len(int top);
        case ($urandom_range(0, 9))
            0:       return 16'(DEPTH_LAST());
            1:       return 16'($urandom);
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    function automatic int DEPTH_LAST();
        return RING_DEPTH_DEF - 1;
    endfunction

    // Mostly a drifting price series, with extremes and zeros mixed in.
    function automatic logic [31:0] pick_price();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'($urandom_range(1, 255));
            2:       return 32'hFFFF_FFFF;
            3:       return $urandom;
            default: return prev_price + 32'($urandom_range(0, 512)) - 32'd256;
        endcase
    endfunction

    initial
    begin
        logic [63:0] f;
        logic [63:0] n;
        logic [47:0] w;
        cycles = 0;
        samples_sent = 0;
        cfg_writes = 0;
        stall_mode = 0;
        burst_left = 4;
        prev_price = 32'd25600;
        in_valid = 1'b0;
        price_sample = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAGS_FIRST;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: short lags so that every case shows within a few words.
        set_all({16'd3, 16'd2, 16'd1, 16'd0}, {16'd7, 16'd6, 16'd5, 16'd4}, 16'd8,
                {16'd8, 16'd2, 16'd0});
        send_word(32'd0);
        send_word(32'd0);
        send_word(32'd1);
        send_word(32'hFFFF_FFFF);
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_word(32'd1);
        send_word(32'h8000_0000);
        send_word(32'd256);
        send_word(32'd512);
        send_word(32'd128);
        send_word(32'hFFFF_FFFF);
        send_word(32'hFFFF_FFFE);
        send_word(32'd1);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        send_word(32'd25600);
        send_word(32'd25601);
        send_word(32'd25599);
        send_word(32'd0);

        // Register extremes: all ones makes every lag too long, all zeros the shortest.
        set_all('1, '1, '1, '1);
        repeat (15)
            send_word(pick_price());
        set_all('0, '0, '0, '0);
        repeat (15)
            send_word(pick_price());

        // Random settings, mostly short lags; sums carry over unrebuilt.
        for (int phase = 0; phase < 5; phase++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                f[16*i +: 16] = pick_len(40);
                n[16*i +: 16] = pick_len(40);
            end
            for (int i = 0; i < 3; i++)
                w[16*i +: 16] = pick_len(30);
            set_all(f, n, pick_len(60), w);
            for (int k = 0; k < 24; k++)
            begin
                // Hold off once mid-phase until the block has drained.
                if (phase == 2 && k == 12)
                begin
                    in_valid = 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
                send_word(pick_price());
            end
        end

        wait_idle();
        $display("Sent %0d price words over %0d register writes; %0d indicator words checked.",
                 samples_sent, cfg_writes, checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
